/* rtl/core/pqft_pkg.sv */
// ----------------------------------------------------------------------------
// pqft_pkg
// Shared types and constants for the stable four-level priority queue.
// ----------------------------------------------------------------------------
package pqft_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 16;
    localparam int KIND_W       = 2;
    localparam int LEVEL_W      = 2;
    localparam int STATUS_W     = 3;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT    = 2'd0,
        K_SERVE_ONE = 2'd1,
        K_SERVE_ALL = 2'd2,
        K_DISMISS   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_SERVED    = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_INSERTED  = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_DISMISSED = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

/* rtl/core/pqft_cell.sv */
// ----------------------------------------------------------------------------
// pqft_cell
// One slot of the sorted queue: holds an entry, compares it against the
// request level and loads from the request, its left or its right neighbor.
// ----------------------------------------------------------------------------
module pqft_cell #(
    parameter int TAG_BITS = pqft_pkg::TAG_BITS_DEF
) (
    input  logic                         clk,
    input  pqft_pkg::cell_ctrl_t         ctrl,
    input  logic                         occupied,
    input  logic [pqft_pkg::LEVEL_W-1:0] new_level,
    input  logic [TAG_BITS-1:0]          new_tag,
    input  logic                         left_ge,
    input  logic [pqft_pkg::LEVEL_W-1:0] left_level,
    input  logic [TAG_BITS-1:0]          left_tag,
    input  logic [pqft_pkg::LEVEL_W-1:0] right_level,
    input  logic [TAG_BITS-1:0]          right_tag,
    output logic [pqft_pkg::LEVEL_W-1:0] level,
    output logic [TAG_BITS-1:0]          tag,
    output logic                         ge
);
    import pqft_pkg::*;

    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  level_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;

    assign ge    = occupied && (level_reg >= new_level);
    assign level = level_reg;
    assign tag   = tag_reg;

    always_comb
    begin
        level_next = level_reg;
        tag_next   = tag_reg;
        if (ctrl.insert)
        begin
            if (!left_ge)
            begin
                level_next = left_level;
                tag_next   = left_tag;
            end
            else if (!ge)
            begin
                level_next = new_level;
                tag_next   = new_tag;
            end
        end
        else if (ctrl.shift)
        begin
            level_next = right_level;
            tag_next   = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        tag_reg   <= tag_next;
    end

endmodule

/* rtl/core/priority_queue_fifo_ties_core.sv */
// ----------------------------------------------------------------------------
// priority_queue_fifo_ties_core
// Bounded stable priority queue built as a sorted row of cells.
// ----------------------------------------------------------------------------
// An insert places the entry behind all entries of the same or higher level
// through a single parallel compare over the cell row, serve one and dismiss
// each give a single result, and serve all streams one served entry per cycle
// out of the head cell, whenever the result register can take it, while new
// requests wait. A request is taken when no serve all is running and the
// result register is empty or being drained in the same cycle.
module priority_queue_fifo_ties_core #(
    parameter int DEPTH    = pqft_pkg::DEPTH_DEF,
    parameter int TAG_BITS = pqft_pkg::TAG_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pqft_pkg::KIND_W-1:0]   kind,
    input  logic [pqft_pkg::LEVEL_W-1:0]  level,
    input  logic [TAG_BITS-1:0]           tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pqft_pkg::STATUS_W-1:0] status,
    output logic [pqft_pkg::LEVEL_W-1:0]  served_level,
    output logic [TAG_BITS-1:0]           served_tag,
    output logic [$clog2(DEPTH+1)-1:0]    count,
    output logic                          last
);
    import pqft_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    occ_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [LEVEL_W-1:0]  served_level_reg;
    logic [LEVEL_W-1:0]  served_level_next;
    logic [TAG_BITS-1:0] served_tag_reg;
    logic [TAG_BITS-1:0] served_tag_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                last_reg;
    logic                last_next;

    cell_ctrl_t          ctrl;
    logic                take;
    logic                accept;

    logic [LEVEL_W-1:0]  lvl_w [DEPTH];
    logic [TAG_BITS-1:0] tag_w [DEPTH];
    logic                ge_w  [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                left_ge;
            logic [LEVEL_W-1:0]  left_level;
            logic [TAG_BITS-1:0] left_tag;
            logic [LEVEL_W-1:0]  right_level;
            logic [TAG_BITS-1:0] right_tag;

            if (gi == 0)
            begin : g_head
                assign left_ge    = 1'b1;
                assign left_level = level;
                assign left_tag   = tag;
            end
            else
            begin : g_body
                assign left_ge    = ge_w[gi-1];
                assign left_level = lvl_w[gi-1];
                assign left_tag   = tag_w[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_level = lvl_w[gi];
                assign right_tag   = tag_w[gi];
            end
            else
            begin : g_inner
                assign right_level = lvl_w[gi+1];
                assign right_tag   = tag_w[gi+1];
            end

            pqft_cell #(
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occ_reg > CNT_W'(gi)),
                .new_level   (level),
                .new_tag     (tag),
                .left_ge     (left_ge),
                .left_level  (left_level),
                .left_tag    (left_tag),
                .right_level (right_level),
                .right_tag   (right_tag),
                .level       (lvl_w[gi]),
                .tag         (tag_w[gi]),
                .ge          (ge_w[gi])
            );
        end
    endgenerate

    assign take     = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next        = state_reg;
        occ_next          = occ_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        status_next       = status_reg;
        served_level_next = served_level_reg;
        served_tag_next   = served_tag_reg;
        count_next        = count_reg;
        last_next         = last_reg;
        ctrl              = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next    = 1'b1;
                    served_level_next = '0;
                    served_tag_next   = '0;
                    last_next         = 1'b1;
                    case (kind)
                        K_INSERT:
                        begin
                            if (occ_reg == FULL_CNT)
                            begin
                                status_next = STAT_FULL;
                                count_next  = occ_reg;
                            end
                            else
                            begin
                                ctrl.insert = 1'b1;
                                occ_next    = occ_reg + ONE_CNT;
                                status_next = STAT_INSERTED;
                                count_next  = occ_reg + ONE_CNT;
                            end
                        end
                        K_DISMISS:
                        begin
                            status_next = STAT_DISMISSED;
                            count_next  = occ_reg;
                            occ_next    = '0;
                        end
                        default:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                count_next  = '0;
                            end
                            else
                            begin
                                ctrl.shift        = 1'b1;
                                occ_next          = occ_reg - ONE_CNT;
                                status_next       = STAT_SERVED;
                                served_level_next = lvl_w[0];
                                served_tag_next   = tag_w[0];
                                count_next        = occ_reg - ONE_CNT;
                                if (kind == K_SERVE_ALL && occ_reg != ONE_CNT)
                                begin
                                    last_next  = 1'b0;
                                    state_next = ST_DRAIN;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (take)
                begin
                    ctrl.shift        = 1'b1;
                    occ_next          = occ_reg - ONE_CNT;
                    out_valid_next    = 1'b1;
                    status_next       = STAT_SERVED;
                    served_level_next = lvl_w[0];
                    served_tag_next   = tag_w[0];
                    count_next        = occ_reg - ONE_CNT;
                    last_next         = (occ_reg == ONE_CNT);
                    if (occ_reg == ONE_CNT)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        served_level_reg <= served_level_next;
        served_tag_reg   <= served_tag_next;
        count_reg        <= count_next;
        last_reg         <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign served_level = served_level_reg;
    assign served_tag   = served_tag_reg;
    assign count        = count_reg;
    assign last         = last_reg;

endmodule

/* rtl/core/pqft_checker.sv */
// ----------------------------------------------------------------------------
// pqft_checker
// Port-level checks on the priority queue results, bound to the top level.
// ----------------------------------------------------------------------------
module pqft_checker #(
    parameter int DEPTH    = pqft_pkg::DEPTH_DEF,
    parameter int TAG_BITS = pqft_pkg::TAG_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [pqft_pkg::STATUS_W-1:0] status,
    input logic [pqft_pkg::LEVEL_W-1:0]  served_level,
    input logic [TAG_BITS-1:0]           served_tag,
    input logic [$clog2(DEPTH+1)-1:0]    count,
    input logic                          last
);
    import pqft_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
            && $stable(served_level) && $stable(served_tag) && $stable(last))
        else $error("result changed while stalled");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_SERVED |-> last)
        else $error("non-serve result without last mark");

    a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_SERVED |-> served_level == '0 && served_tag == '0)
        else $error("non-serve result carries an entry");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_FULL |-> count == CNT_W'(DEPTH))
        else $error("full rejection with queue not full");

    a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_SERVED && !last |-> !in_ready)
        else $error("request taken during serve-all run");

endmodule

bind priority_queue_fifo_ties_core pqft_checker #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
) u_pqft_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .served_level (served_level),
    .served_tag   (served_tag),
    .count        (count),
    .last         (last)
);
